[design/h2t_pkg.sv]
`timescale 1ns / 1ps

package h2t_pkg;

    // Default sizes handed to the top level
    localparam int LOOKAHEAD_DEPTH_DEF    = 12;
    localparam int TAG_NAME_MAX_DEF       = 10;
    localparam int NEWLINE_COUNT_BITS_DEF = 16;

    // Depth of the queue between front and back
    localparam int FIFO_DEPTH = 4;

    // Code point limits
    localparam logic [20:0] CP_LIMIT = 21'h10FFFF;
    localparam logic [20:0] CP_SAT   = 21'h110000;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;

    // Kinds of item passed from front to back
    typedef enum logic [1:0] {
        TOK_BYTE = 2'd0,
        TOK_END  = 2'd1,
        TOK_EOT  = 2'd2
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] data;
    } token_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SP) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return is_digit(b) || (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    endfunction

    // Valid flag over a four-bit hex digit value
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [7:0] d;
        d = 8'h00;
        if (is_digit(b)) begin
            d = b - 8'h30;
            return {1'b1, d[3:0]};
        end
        if (b >= 8'h61 && b <= 8'h66) begin
            d = b - 8'h57;
            return {1'b1, d[3:0]};
        end
        if (b >= 8'h41 && b <= 8'h46) begin
            d = b - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'd0;
    endfunction

endpackage

[design/h2t_if.sv]
`timescale 1ns / 1ps

interface h2t_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] text_byte;

    modport source (output valid, output func, output text_byte, input ready);
    modport sink (input valid, input func, input text_byte, output ready);
endinterface

interface h2t_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [15:0] repeat_res;
    logic        end_of_text;
    logic        last_of_run;

    modport source (output valid, output out_byte, output repeat_res,
                    output end_of_text, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input repeat_res,
                  input end_of_text, input last_of_run, output ready);
endinterface

[design/h2t_front.sv]
`timescale 1ns / 1ps

module h2t_front
    import h2t_pkg::*;
#(
    parameter int LOOKAHEAD_DEPTH = LOOKAHEAD_DEPTH_DEF,
    parameter int TAG_NAME_MAX    = TAG_NAME_MAX_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    h2t_in_if.sink    text_in,
    output logic      tok_valid,
    output token_t    tok,
    input  logic      tok_ready
);

    localparam int BUF_DEPTH = 2 ** $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int LA_CW     = $clog2(LOOKAHEAD_DEPTH + 1);
    localparam int LA_AW     = $clog2(LOOKAHEAD_DEPTH);
    localparam int TN_CW     = $clog2(TAG_NAME_MAX + 1);
    localparam int TN_AW     = $clog2(TAG_NAME_MAX);
    localparam int ENT_WIN   = 6;

    // Tag scan phases
    localparam logic [1:0] PH_LEAD = 2'd0;
    localparam logic [1:0] PH_NAME = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    typedef enum logic [1:0] {
        F_RUN  = 2'b01,
        F_EMIT = 2'b10
    } fstate_t;

    fstate_t            state_reg, state_next;
    logic [7:0]         rbuf_reg [BUF_DEPTH];
    logic [BUF_AW-1:0]  rd_reg, rd_next, wr_reg, wr_next, mark_reg, mark_next;
    logic               step_reg, step_next, eot_reg, eot_next;
    logic               in_tag_reg, in_tag_next, skip_reg, skip_next;
    logic [1:0]         phase_reg, phase_next;
    logic               closing_reg, closing_next;
    logic [7:0]         tag_name_reg [TAG_NAME_MAX];
    logic [TN_CW-1:0]   tn_len_reg, tn_len_next;
    logic               tn_long_reg, tn_long_next;
    logic [7:0]         look_reg [LOOKAHEAD_DEPTH];
    logic [LA_CW-1:0]   la_cnt_reg, la_cnt_next;
    logic               coll_reg, coll_next;
    logic               num_ok_reg, num_ok_next, hex_reg, hex_next;
    logic [20:0]        cp_reg, cp_next;
    logic [7:0]         last_reg, last_next;
    logic               empty_reg, empty_next;
    logic [7:0]         em_byte_reg [4];
    logic [2:0]         em_cnt_reg, em_cnt_next;
    logic [1:0]         em_idx_reg, em_idx_next;

    logic [7:0]         b;
    logic [7:0]         em_new [4];
    logic [2:0]         em_n;
    logic               tn_we, la_we, rb_we;
    logic [LA_CW-1:0]   cnt_inc;
    logic [7:0]         la_win [ENT_WIN];
    logic [4:0]         dig;
    logic [24:0]        cp_mul;
    logic [24:0]        cp_sum;
    logic               is_script_style, skip_new, nl_need, nl_tag;
    logic               num_good;

    // Zero-padded window over the first held entity bytes
    for (genvar g = 0; g < ENT_WIN; g++) begin : g_win
        if (g < LOOKAHEAD_DEPTH) begin : g_have
            assign la_win[g] = look_reg[g];
        end else begin : g_pad
            assign la_win[g] = CH_NUL;
        end
    end

    function automatic logic tag_is(input logic [79:0] pat, input logic [3:0] plen);
        logic ok;
        ok = !tn_long_reg && (tn_len_reg == TN_CW'(plen));
        for (int i = 0; i < 10; i++) begin
            if (i < plen && tag_name_reg[i] != pat[(int'(plen) - 1 - i) * 8 +: 8]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic ent_is(input logic [47:0] pat, input logic [2:0] plen);
        logic ok;
        ok = (la_cnt_reg == LA_CW'(plen));
        for (int i = 0; i < ENT_WIN; i++) begin
            if (i < plen && la_win[i] != pat[(int'(plen) - 1 - i) * 8 +: 8]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    assign b       = rbuf_reg[rd_reg];
    assign cnt_inc = la_cnt_reg + LA_CW'(1);

    // Digit value and saturating accumulate for numeric entities
    always_comb
    begin
        if (hex_reg) begin
            dig    = hex_val(b);
            cp_mul = {cp_reg, 4'b0000};
        end else begin
            dig    = {is_digit(b), b[3:0]};
            cp_mul = {1'b0, cp_reg, 3'b000} + {3'b000, cp_reg, 1'b0};
        end
        cp_sum = cp_mul + {21'd0, dig[3:0]};
    end

    assign num_good = num_ok_reg && (la_cnt_reg != '0) && (cp_reg != 21'd0);

    // Match the finished tag name against the known tags
    always_comb
    begin
        is_script_style = tag_is("script", 4'd6) || tag_is("style", 4'd5);
        skip_new        = is_script_style ? !closing_reg : skip_reg;
        nl_need         = empty_reg || (last_reg != CH_LF);
        nl_tag = tag_is("br", 4'd2) || tag_is("p", 4'd1) || tag_is("div", 4'd3)
              || tag_is("ul", 4'd2) || tag_is("ol", 4'd2) || tag_is("h1", 4'd2)
              || tag_is("h2", 4'd2) || tag_is("h3", 4'd2) || tag_is("h4", 4'd2)
              || tag_is("h5", 4'd2) || tag_is("h6", 4'd2)
              || tag_is("blockquote", 4'd10);
    end

    // Classify the next byte and sequence the emitted bytes
    always_comb
    begin
        state_next   = state_reg;
        rd_next      = rd_reg;
        wr_next      = wr_reg;
        mark_next    = mark_reg;
        step_next    = step_reg;
        eot_next     = eot_reg;
        in_tag_next  = in_tag_reg;
        skip_next    = skip_reg;
        phase_next   = phase_reg;
        closing_next = closing_reg;
        tn_len_next  = tn_len_reg;
        tn_long_next = tn_long_reg;
        la_cnt_next  = la_cnt_reg;
        coll_next    = coll_reg;
        num_ok_next  = num_ok_reg;
        hex_next     = hex_reg;
        cp_next      = cp_reg;
        last_next    = last_reg;
        empty_next   = empty_reg;
        em_cnt_next  = em_cnt_reg;
        em_idx_next  = em_idx_reg;
        em_n         = 3'd0;
        for (int i = 0; i < 4; i++) begin
            em_new[i] = CH_NUL;
        end
        tn_we         = 1'b0;
        la_we         = 1'b0;
        rb_we         = 1'b0;
        text_in.ready = 1'b0;
        tok_valid     = 1'b0;
        tok           = '{kind: TOK_END, data: CH_NUL};

        unique case (state_reg)
            F_RUN:
            begin
                if (rd_reg != wr_reg) begin
                    rd_next = rd_reg + BUF_AW'(1);
                    if (coll_reg) begin
                        // Hold the byte and track a numeric value on the way
                        la_we       = 1'b1;
                        la_cnt_next = cnt_inc;
                        if (b != CH_SEMI) begin
                            if (la_cnt_reg == '0) begin
                                num_ok_next = (b == CH_HASH);
                                hex_next    = 1'b0;
                                cp_next     = 21'd0;
                            end else if (la_cnt_reg == LA_CW'(1) && (b == 8'h78 || b == 8'h58))
                            begin
                                hex_next = 1'b1;
                            end else if (!dig[4]) begin
                                num_ok_next = 1'b0;
                            end else if (cp_sum > {4'd0, CP_LIMIT}) begin
                                cp_next = CP_SAT;
                            end else begin
                                cp_next = cp_sum[20:0];
                            end
                        end
                        if (b == CH_SEMI) begin
                            coll_next   = 1'b0;
                            la_cnt_next = '0;
                            if (ent_is("amp", 3'd3)) begin
                                em_new[0] = CH_AMP;
                                em_n      = 3'd1;
                            end else if (ent_is("lt", 3'd2)) begin
                                em_new[0] = CH_LT;
                                em_n      = 3'd1;
                            end else if (ent_is("gt", 3'd2)) begin
                                em_new[0] = CH_GT;
                                em_n      = 3'd1;
                            end else if (ent_is("quot", 3'd4)) begin
                                em_new[0] = CH_QUOT;
                                em_n      = 3'd1;
                            end else if (ent_is("apos", 3'd4) || ent_is("#39", 3'd3)) begin
                                em_new[0] = CH_APOS;
                                em_n      = 3'd1;
                            end else if (ent_is("nbsp", 3'd4)) begin
                                em_new[0] = CH_SP;
                                em_n      = 3'd1;
                            end else if (ent_is("mdash", 3'd5)) begin
                                em_new[0] = CH_DASH;
                                em_new[1] = CH_DASH;
                                em_n      = 3'd2;
                            end else if (ent_is("ndash", 3'd5)) begin
                                em_new[0] = CH_DASH;
                                em_n      = 3'd1;
                            end else if (ent_is("hellip", 3'd6)) begin
                                em_new[0] = CH_DOT;
                                em_new[1] = CH_DOT;
                                em_new[2] = CH_DOT;
                                em_n      = 3'd3;
                            end else if (num_good) begin
                                // Encode the code point as UTF-8
                                if (cp_reg <= 21'h7F) begin
                                    em_new[0] = cp_reg[7:0];
                                    em_n      = 3'd1;
                                end else if (cp_reg <= 21'h7FF) begin
                                    em_new[0] = 8'hC0 | {3'b000, cp_reg[10:6]};
                                    em_new[1] = 8'h80 | {2'b00, cp_reg[5:0]};
                                    em_n      = 3'd2;
                                end else if (cp_reg <= 21'hFFFF) begin
                                    em_new[0] = 8'hE0 | {4'h0, cp_reg[15:12]};
                                    em_new[1] = 8'h80 | {2'b00, cp_reg[11:6]};
                                    em_new[2] = 8'h80 | {2'b00, cp_reg[5:0]};
                                    em_n      = 3'd3;
                                end else if (cp_reg <= CP_LIMIT) begin
                                    em_new[0] = 8'hF0 | {5'd0, cp_reg[20:18]};
                                    em_new[1] = 8'h80 | {2'b00, cp_reg[17:12]};
                                    em_new[2] = 8'h80 | {2'b00, cp_reg[11:6]};
                                    em_new[3] = 8'h80 | {2'b00, cp_reg[5:0]};
                                    em_n      = 3'd4;
                                end
                            end else begin
                                // Not an entity: give the ampersand, replay the held bytes
                                em_new[0] = CH_AMP;
                                em_n      = 3'd1;
                                rd_next   = mark_reg;
                            end
                        end else if (cnt_inc == LA_CW'(LOOKAHEAD_DEPTH)) begin
                            coll_next   = 1'b0;
                            la_cnt_next = '0;
                            em_new[0]   = CH_AMP;
                            em_n        = 3'd1;
                            rd_next     = mark_reg;
                        end
                    end else if (in_tag_reg) begin
                        if (b == CH_GT) begin
                            in_tag_next = 1'b0;
                            skip_next   = skip_new;
                            if (!skip_new) begin
                                if (nl_tag) begin
                                    em_new[0] = CH_LF;
                                    em_n      = nl_need ? 3'd1 : 3'd0;
                                end else if (tag_is("li", 4'd2)) begin
                                    if (nl_need) begin
                                        em_new[0] = CH_LF;
                                        em_new[1] = CH_DASH;
                                        em_new[2] = CH_SP;
                                        em_n      = 3'd3;
                                    end else begin
                                        em_new[0] = CH_DASH;
                                        em_new[1] = CH_SP;
                                        em_n      = 3'd2;
                                    end
                                end
                            end
                        end else if (phase_reg == PH_LEAD) begin
                            if (is_ws(b)) begin
                                phase_next = PH_LEAD;
                            end else if (b == CH_SLASH) begin
                                closing_next = 1'b1;
                                phase_next   = PH_NAME;
                            end else if (is_alnum(b)) begin
                                tn_we      = 1'b1;
                                phase_next = PH_NAME;
                            end else begin
                                phase_next = PH_DONE;
                            end
                        end else if (phase_reg == PH_NAME) begin
                            if (is_alnum(b)) begin
                                tn_we = 1'b1;
                            end else begin
                                phase_next = PH_DONE;
                            end
                        end
                        // Store a name letter or mark the name as too long
                        if (tn_we) begin
                            if (tn_len_reg < TN_CW'(TAG_NAME_MAX)) begin
                                tn_len_next = tn_len_reg + TN_CW'(1);
                            end else begin
                                tn_we        = 1'b0;
                                tn_long_next = 1'b1;
                            end
                        end
                    end else if (b == CH_LT) begin
                        in_tag_next  = 1'b1;
                        phase_next   = PH_LEAD;
                        closing_next = 1'b0;
                        tn_len_next  = '0;
                        tn_long_next = 1'b0;
                    end else if (skip_reg) begin
                        em_n = 3'd0;
                    end else if (b == CH_AMP) begin
                        coll_next   = 1'b1;
                        la_cnt_next = '0;
                        mark_next   = rd_reg + BUF_AW'(1);
                    end else begin
                        em_new[0] = b;
                        em_n      = 3'd1;
                    end

                    // First emitted byte goes straight out when the queue has room
                    if (em_n != 3'd0) begin
                        tok_valid   = 1'b1;
                        tok         = '{kind: TOK_BYTE, data: em_new[0]};
                        em_cnt_next = em_n;
                        if (tok_ready) begin
                            last_next   = em_new[0];
                            empty_next  = 1'b0;
                            em_idx_next = 2'd1;
                            if (em_n != 3'd1) begin
                                state_next = F_EMIT;
                            end
                        end else begin
                            em_idx_next = 2'd0;
                            state_next  = F_EMIT;
                        end
                    end
                end else if (eot_reg) begin
                    if (coll_reg) begin
                        // Open entity at end of text fails
                        coll_next   = 1'b0;
                        la_cnt_next = '0;
                        rd_next     = mark_reg;
                        em_new[0]   = CH_AMP;
                        em_n        = 3'd1;
                        em_cnt_next = 3'd1;
                        em_idx_next = 2'd0;
                        state_next  = F_EMIT;
                    end else begin
                        tok_valid = 1'b1;
                        tok       = '{kind: TOK_EOT, data: CH_NUL};
                        if (tok_ready) begin
                            eot_next     = 1'b0;
                            in_tag_next  = 1'b0;
                            skip_next    = 1'b0;
                            phase_next   = PH_LEAD;
                            closing_next = 1'b0;
                            tn_len_next  = '0;
                            tn_long_next = 1'b0;
                            last_next    = CH_NUL;
                            empty_next   = 1'b1;
                        end
                    end
                end else begin
                    // Close the previous step and take the next item together
                    if (step_reg) begin
                        tok_valid = 1'b1;
                        tok       = '{kind: TOK_END, data: CH_NUL};
                    end
                    text_in.ready = !step_reg || tok_ready;
                    if (step_reg && tok_ready) begin
                        step_next = 1'b0;
                    end
                    if (text_in.valid && text_in.ready) begin
                        step_next = 1'b1;
                        if (text_in.func) begin
                            eot_next = 1'b1;
                        end else begin
                            rb_we   = 1'b1;
                            wr_next = wr_reg + BUF_AW'(1);
                        end
                    end
                end
            end

            F_EMIT:
            begin
                tok_valid = 1'b1;
                tok       = '{kind: TOK_BYTE, data: em_byte_reg[em_idx_reg]};
                if (tok_ready) begin
                    last_next   = em_byte_reg[em_idx_reg];
                    empty_next  = 1'b0;
                    em_idx_next = em_idx_reg + 2'd1;
                    if ({1'b0, em_idx_reg} == em_cnt_reg - 3'd1) begin
                        state_next = F_RUN;
                    end
                end
            end

            default:
            begin
                state_next = F_RUN;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= F_RUN;
            rd_reg      <= '0;
            wr_reg      <= '0;
            mark_reg    <= '0;
            step_reg    <= 1'b0;
            eot_reg     <= 1'b0;
            in_tag_reg  <= 1'b0;
            skip_reg    <= 1'b0;
            phase_reg   <= PH_LEAD;
            closing_reg <= 1'b0;
            tn_len_reg  <= '0;
            tn_long_reg <= 1'b0;
            la_cnt_reg  <= '0;
            coll_reg    <= 1'b0;
            num_ok_reg  <= 1'b0;
            hex_reg     <= 1'b0;
            cp_reg      <= 21'd0;
            last_reg    <= CH_NUL;
            empty_reg   <= 1'b1;
            em_cnt_reg  <= 3'd0;
            em_idx_reg  <= 2'd0;
        end else begin
            state_reg   <= state_next;
            rd_reg      <= rd_next;
            wr_reg      <= wr_next;
            mark_reg    <= mark_next;
            step_reg    <= step_next;
            eot_reg     <= eot_next;
            in_tag_reg  <= in_tag_next;
            skip_reg    <= skip_next;
            phase_reg   <= phase_next;
            closing_reg <= closing_next;
            tn_len_reg  <= tn_len_next;
            tn_long_reg <= tn_long_next;
            la_cnt_reg  <= la_cnt_next;
            coll_reg    <= coll_next;
            num_ok_reg  <= num_ok_next;
            hex_reg     <= hex_next;
            cp_reg      <= cp_next;
            last_reg    <= last_next;
            empty_reg   <= empty_next;
            em_cnt_reg  <= em_cnt_next;
            em_idx_reg  <= em_idx_next;
        end
    end

    // Payload stores
    always_ff @(posedge clk)
    begin
        if (rb_we) begin
            rbuf_reg[wr_reg] <= text_in.text_byte;
        end
        if (tn_we) begin
            tag_name_reg[tn_len_reg[TN_AW-1:0]] <= to_lower(b);
        end
        if (la_we) begin
            look_reg[la_cnt_reg[LA_AW-1:0]] <= b;
        end
        if (em_n != 3'd0) begin
            for (int i = 0; i < 4; i++) begin
                em_byte_reg[i] <= em_new[i];
            end
        end
    end

    // Held entity bytes never reach the lookahead depth between steps
    a_la_bound: assert property (@(posedge clk) disable iff (!rst_n)
        la_cnt_reg < LA_CW'(LOOKAHEAD_DEPTH))
        else $error("entity hold count reached its limit");

endmodule

[design/h2t_fifo.sv]
`timescale 1ns / 1ps

module h2t_fifo
    import h2t_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  token_t in_tok,
    output logic   out_valid,
    input  logic   out_ready,
    output token_t out_tok
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    token_t          mem_reg [FIFO_DEPTH];
    logic [AW-1:0]   wp_reg, rp_reg;
    logic [CW-1:0]   cnt_reg;
    logic            push, pop;

    assign in_ready  = (cnt_reg != CW'(FIFO_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_tok   = mem_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == AW'(FIFO_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
            end
            if (pop) begin
                rp_reg <= (rp_reg == AW'(FIFO_DEPTH - 1)) ? '0 : rp_reg + AW'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    // Hold the queued items
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wp_reg] <= in_tok;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(FIFO_DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

[design/h2t_back.sv]
`timescale 1ns / 1ps

module h2t_back
    import h2t_pkg::*;
#(
    parameter int NEWLINE_COUNT_BITS = NEWLINE_COUNT_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      tok_valid,
    output logic      tok_ready,
    input  token_t    tok,
    h2t_out_if.source text_out
);

    localparam int PN_W = (NEWLINE_COUNT_BITS < 16) ? NEWLINE_COUNT_BITS : 16;

    logic             in_space_reg, in_space_next;
    logic [1:0]       streak_reg, streak_next;
    logic [PN_W-1:0]  pend_nl_reg, pend_nl_next;
    logic             pend_sp_reg, pend_sp_next;
    logic             hold_valid_reg, hold_valid_next;
    logic [7:0]       hold_byte_reg, hold_byte_next;
    logic [15:0]      hold_rep_reg, hold_rep_next;
    logic             hold_eot_reg, hold_eot_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [15:0]      out_rep_reg;
    logic             out_eot_reg, out_last_reg;

    logic             out_free, push_ok, push, out_load, load_last;
    logic [7:0]       push_byte, cb;
    logic [15:0]      push_rep;
    logic             push_eot;

    assign out_free = !out_valid_reg || text_out.ready;
    assign push_ok  = !hold_valid_reg || out_free;
    assign cb       = (tok.data == CH_CR) ? CH_LF : tok.data;

    // Collapse whitespace and form result items
    always_comb
    begin
        in_space_next = in_space_reg;
        streak_next   = streak_reg;
        pend_nl_next  = pend_nl_reg;
        pend_sp_next  = pend_sp_reg;
        tok_ready     = 1'b0;
        push          = 1'b0;
        push_byte     = CH_NUL;
        push_rep      = 16'd1;
        push_eot      = 1'b0;
        load_last     = 1'b0;
        if (tok_valid) begin
            case (tok.kind)
                TOK_BYTE:
                begin
                    if (cb == CH_LF) begin
                        tok_ready     = 1'b1;
                        pend_sp_next  = 1'b0;
                        in_space_next = 1'b0;
                        if (streak_reg < 2'd2) begin
                            streak_next = streak_reg + 2'd1;
                            if (pend_nl_reg != {PN_W{1'b1}}) begin
                                pend_nl_next = pend_nl_reg + PN_W'(1);
                            end
                        end
                    end else if (is_ws(cb)) begin
                        tok_ready   = 1'b1;
                        streak_next = 2'd0;
                        if (!in_space_reg) begin
                            pend_sp_next  = 1'b1;
                            in_space_next = 1'b1;
                        end
                    end else if (push_ok) begin
                        // Give held newlines, then a held space, then the byte
                        push = 1'b1;
                        if (pend_nl_reg != '0) begin
                            push_byte    = CH_LF;
                            push_rep     = 16'(pend_nl_reg);
                            pend_nl_next = '0;
                        end else if (pend_sp_reg) begin
                            push_byte    = CH_SP;
                            pend_sp_next = 1'b0;
                        end else begin
                            push_byte     = cb;
                            tok_ready     = 1'b1;
                            in_space_next = 1'b0;
                            streak_next   = 2'd0;
                        end
                    end
                end
                TOK_EOT:
                begin
                    // Drop held whitespace and give the end marker
                    if (push_ok) begin
                        push          = 1'b1;
                        push_rep      = 16'd0;
                        push_eot      = 1'b1;
                        tok_ready     = 1'b1;
                        in_space_next = 1'b0;
                        streak_next   = 2'd0;
                        pend_nl_next  = '0;
                        pend_sp_next  = 1'b0;
                    end
                end
                TOK_END:
                begin
                    if (!hold_valid_reg) begin
                        tok_ready = 1'b1;
                    end else if (out_free) begin
                        tok_ready = 1'b1;
                        load_last = 1'b1;
                    end
                end
                default:
                begin
                    tok_ready = 1'b1;
                end
            endcase
        end
    end

    // Move the held item to the output when a newer one arrives or the step ends
    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        hold_rep_next   = hold_rep_reg;
        hold_eot_next   = hold_eot_reg;
        out_load        = 1'b0;
        if (push) begin
            out_load        = hold_valid_reg;
            hold_valid_next = 1'b1;
            hold_byte_next  = push_byte;
            hold_rep_next   = push_rep;
            hold_eot_next   = push_eot;
        end else if (load_last) begin
            out_load        = 1'b1;
            hold_valid_next = 1'b0;
        end
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (text_out.ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_space_reg   <= 1'b0;
            streak_reg     <= 2'd0;
            pend_nl_reg    <= '0;
            pend_sp_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            in_space_reg   <= in_space_next;
            streak_reg     <= streak_next;
            pend_nl_reg    <= pend_nl_next;
            pend_sp_reg    <= pend_sp_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_byte_reg <= hold_byte_next;
        hold_rep_reg  <= hold_rep_next;
        hold_eot_reg  <= hold_eot_next;
        if (out_load) begin
            out_byte_reg <= hold_byte_reg;
            out_rep_reg  <= hold_rep_reg;
            out_eot_reg  <= hold_eot_reg;
            out_last_reg <= load_last;
        end
    end

    assign text_out.valid       = out_valid_reg;
    assign text_out.out_byte    = out_byte_reg;
    assign text_out.repeat_res  = out_rep_reg;
    assign text_out.end_of_text = out_eot_reg;
    assign text_out.last_of_run = out_last_reg;

    // The end marker always closes its step
    a_eot_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_eot_reg |-> out_last_reg)
        else $error("end marker shown without last flag");

endmodule

[design/html_to_plain_text_stream.sv]
`timescale 1ns / 1ps

// Channel   | Dir | Payload                                          | Handshake
// text_in   | in  | func, text_byte                                  | valid/ready
// text_out  | out | out_byte, repeat_res, end_of_text, last_of_run   | valid/ready
//
// A plain text byte is first classified and emitted, then its step is closed.
// Further bytes from an entity or a list tag go out through the front emit sequencer;
// a failed entity replays its held bytes through the front classifier.
// The back gives one item a cycle unless the output stalls; held newlines and a held space go out ahead of the byte.
// Reset is asynchronous, active low, and needs no clearing pass.
// Either side may stall on its own; a four-entry queue parts front and back.
module html_to_plain_text_stream
    import h2t_pkg::*;
#(
    parameter int LOOKAHEAD_DEPTH    = LOOKAHEAD_DEPTH_DEF,
    parameter int TAG_NAME_MAX       = TAG_NAME_MAX_DEF,
    parameter int NEWLINE_COUNT_BITS = NEWLINE_COUNT_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    h2t_in_if.sink    text_in,
    h2t_out_if.source text_out
);

    logic   f_valid, f_ready, b_valid, b_ready;
    token_t f_tok, b_tok;

    h2t_front #(
        .LOOKAHEAD_DEPTH (LOOKAHEAD_DEPTH),
        .TAG_NAME_MAX    (TAG_NAME_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_in   (text_in),
        .tok_valid (f_valid),
        .tok       (f_tok),
        .tok_ready (f_ready)
    );

    h2t_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_tok    (f_tok),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_tok   (b_tok)
    );

    h2t_back #(
        .NEWLINE_COUNT_BITS (NEWLINE_COUNT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (b_valid),
        .tok_ready (b_ready),
        .tok       (b_tok),
        .text_out  (text_out)
    );

endmodule

[tb/tb_html_to_plain_text_stream.sv]
`timescale 1ns / 1ps

module tb_html_to_plain_text_stream;
    import h2t_pkg::*;

    localparam int LA_DEPTH  = 12;
    localparam int NAME_MAX  = 10;
    localparam int WORK_SIZE = 2 * LA_DEPTH + 2;
    localparam int MAX_ITEMS = 64;
    localparam int STALL_LIMIT = 20000;

    // Kinds of input item
    localparam logic FN_BYTE = 1'b0;
    localparam logic FN_END  = 1'b1;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [15:0] repeat_res;
        logic        end_of_text;
        logic        last_of_run;
    } text_item_t;

    typedef struct packed {
        logic       func;
        logic [7:0] text_byte;
    } html_item_t;

    logic clk = 1'b0;
    logic rst_n;

    h2t_in_if  text_in ();
    h2t_out_if text_out ();

    html_to_plain_text_stream uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .text_out (text_out)
    );

    // Predictor state
    logic        p_in_tag, p_skip, p_closing, p_name_long, p_collect, p_s1_empty;
    logic [1:0]  p_phase, p_nl_streak;
    logic [7:0]  p_name [NAME_MAX];
    int          p_name_len;
    logic [7:0]  p_look [LA_DEPTH];
    int          p_look_cnt;
    logic [7:0]  p_last;
    logic        p_in_space, p_pend_space;
    int          p_pend_nl;
    logic [7:0]  p_work [WORK_SIZE];
    int          p_work_len, p_rp;
    text_item_t  step_items [$];

    html_item_t  pending_html [$];
    text_item_t  expected_text [$];
    int          mismatches;
    int          results_seen;
    int          eot_seen;
    int          idle_pct;
    int          stall_cycles;
    logic        stim_done;

    always #2 clk = ~clk;

    function automatic logic ws_byte(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic dig_byte(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic alnum_byte(input logic [7:0] b);
        return dig_byte(b) || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic int hex_digit(input logic [7:0] b);
        if (dig_byte(b)) return b - "0";
        if (b >= "a" && b <= "f") return b - "a" + 10;
        if (b >= "A" && b <= "F") return b - "A" + 10;
        return -1;
    endfunction

    task automatic reset_predictor();
        p_in_tag = 0; p_skip = 0; p_phase = 0; p_closing = 0;
        p_name_len = 0; p_name_long = 0; p_look_cnt = 0; p_collect = 0;
        p_rp = 0; p_last = 0; p_s1_empty = 1; p_in_space = 0;
        p_nl_streak = 0; p_pend_nl = 0; p_pend_space = 0; p_work_len = 0;
    endtask

    task automatic push_text(input logic [7:0] b, input int rep);
        text_item_t t;
        if (step_items.size() >= MAX_ITEMS - 1) return;
        t.out_byte = b; t.repeat_res = rep[15:0]; t.end_of_text = 0; t.last_of_run = 0;
        step_items = {step_items, t};
    endtask

    // Whitespace collapse
    task automatic collapse_ws(input logic [7:0] b_in);
        logic [7:0] b;
        b = (b_in == CH_CR) ? CH_LF : b_in;
        if (b == CH_LF) begin
            p_pend_space = 0;
            if (p_nl_streak < 2) begin
                if (p_pend_nl < 16'hFFFF) p_pend_nl++;
                p_nl_streak++;
            end
            p_in_space = 0;
        end else if (ws_byte(b)) begin
            if (!p_in_space) begin
                p_pend_space = 1; p_in_space = 1;
            end
            p_nl_streak = 0;
        end else begin
            if (p_pend_nl != 0) push_text(CH_LF, p_pend_nl);
            if (p_pend_space) push_text(CH_SP, 1);
            push_text(b, 1);
            p_pend_nl = 0; p_pend_space = 0; p_in_space = 0; p_nl_streak = 0;
        end
    endtask

    task automatic emit_plain(input logic [7:0] b);
        p_last = b; p_s1_empty = 0;
        collapse_ws(b);
    endtask

    task automatic emit_str(input string s);
        for (int i = 0; i < s.len(); i++) emit_plain(s[i]);
    endtask

    task automatic emit_nl_once();
        if (p_s1_empty || p_last != CH_LF) emit_plain(CH_LF);
    endtask

    function automatic logic held_is(input int n, input string s);
        if (s.len() != n) return 0;
        for (int i = 0; i < n; i++) if (p_look[i] != s[i]) return 0;
        return 1;
    endfunction

    function automatic logic tag_is(input string s);
        if (p_name_long || s.len() != p_name_len) return 0;
        for (int i = 0; i < p_name_len; i++) if (p_name[i] != s[i]) return 0;
        return 1;
    endfunction

    task automatic emit_utf8(input int unsigned v);
        if (v <= 32'h7F) emit_plain(v[7:0]);
        else if (v <= 32'h7FF) begin
            emit_plain(8'(8'hC0 | ((v >> 6) & 8'h1F)));
            emit_plain(8'(8'h80 | (v & 8'h3F)));
        end else if (v <= 32'hFFFF) begin
            emit_plain(8'(8'hE0 | ((v >> 12) & 8'h0F)));
            emit_plain(8'(8'h80 | ((v >> 6) & 8'h3F)));
            emit_plain(8'(8'h80 | (v & 8'h3F)));
        end else if (v <= 32'h10FFFF) begin
            emit_plain(8'(8'hF0 | ((v >> 18) & 8'h07)));
            emit_plain(8'(8'h80 | ((v >> 12) & 8'h3F)));
            emit_plain(8'(8'h80 | ((v >> 6) & 8'h3F)));
            emit_plain(8'(8'h80 | (v & 8'h3F)));
        end
    endtask

    // Named and numeric entity decode; 0 when not an entity
    task automatic decode_ref(input int n, output logic ok);
        int unsigned v;
        logic hx;
        int d;
        string names [10] = '{"amp", "lt", "gt", "quot", "apos", "#39", "nbsp",
                              "mdash", "ndash", "hellip"};
        string texts [10] = '{"&", "<", ">", "\"", "'", "'", " ", "--", "-", "..."};
        ok = 0;
        for (int k = 0; k < 10; k++)
            if (held_is(n, names[k])) begin
                emit_str(texts[k]); ok = 1; return;
            end
        if (n < 1 || p_look[0] != CH_HASH) return;
        v = 0;
        hx = n > 1 && (p_look[1] == "x" || p_look[1] == "X");
        for (int i = hx ? 2 : 1; i < n; i++) begin
            d = hx ? hex_digit(p_look[i]) : (dig_byte(p_look[i]) ? p_look[i] - "0" : -1);
            if (d < 0) return;
            v = v * (hx ? 16 : 10) + d;
            if (v > 32'h10FFFF) v = 32'h110000;
        end
        if (v == 0) return;
        emit_utf8(v);
        ok = 1;
    endtask

    // Failed entity: emit ampersand and put held bytes back in front of the queue
    task automatic entity_replay();
        logic [7:0] tmp [WORK_SIZE];
        int rest, held;
        rest = p_work_len > p_rp ? p_work_len - p_rp : 0;
        held = p_look_cnt;
        emit_plain(CH_AMP);
        if (held + rest > WORK_SIZE) rest = WORK_SIZE - held;
        for (int i = 0; i < rest; i++) tmp[i] = p_work[p_rp + i];
        for (int i = 0; i < held; i++) p_work[i] = p_look[i];
        for (int i = 0; i < rest; i++) p_work[held + i] = tmp[i];
        p_work_len = held + rest;
        p_rp = 0; p_look_cnt = 0; p_collect = 0;
    endtask

    task automatic name_store(input logic [7:0] b);
        if (p_name_len < NAME_MAX) begin
            p_name[p_name_len] = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
            p_name_len++;
        end else p_name_long = 1;
    endtask

    task automatic close_tag();
        string nl_tags [12] = '{"br", "p", "div", "ul", "ol", "h1", "h2", "h3", "h4",
                                "h5", "h6", "blockquote"};
        p_in_tag = 0;
        if (tag_is("script") || tag_is("style")) p_skip = !p_closing;
        if (p_skip) return;
        for (int k = 0; k < 12; k++)
            if (tag_is(nl_tags[k])) begin
                emit_nl_once(); return;
            end
        if (tag_is("li")) begin
            emit_nl_once(); emit_str("- ");
        end
    endtask

    task automatic markup_byte(input logic [7:0] b);
        logic ok;
        if (p_collect) begin
            if (p_look_cnt < LA_DEPTH) begin
                p_look[p_look_cnt] = b; p_look_cnt++;
            end
            if (b == CH_SEMI) begin
                decode_ref(p_look_cnt - 1, ok);
                if (ok) begin
                    p_collect = 0; p_look_cnt = 0;
                end else entity_replay();
            end else if (p_look_cnt >= LA_DEPTH) entity_replay();
            return;
        end
        if (p_in_tag) begin
            if (b == CH_GT) close_tag();
            else if (p_phase == 0) begin
                if (!ws_byte(b)) begin
                    if (b == CH_SLASH) begin
                        p_closing = 1; p_phase = 1;
                    end else if (alnum_byte(b)) begin
                        name_store(b); p_phase = 1;
                    end else p_phase = 2;
                end
            end else if (p_phase == 1) begin
                if (alnum_byte(b)) name_store(b);
                else p_phase = 2;
            end
            return;
        end
        if (b == CH_LT) begin
            p_in_tag = 1; p_phase = 0; p_closing = 0; p_name_len = 0; p_name_long = 0;
            return;
        end
        if (p_skip) return;
        if (b == CH_AMP) begin
            p_collect = 1; p_look_cnt = 0; return;
        end
        emit_plain(b);
    endtask

    task automatic drain_work();
        while (p_rp < p_work_len && p_rp < WORK_SIZE) begin
            p_rp++;
            markup_byte(p_work[p_rp - 1]);
        end
        p_rp = 0; p_work_len = 0;
    endtask

    // Expected results of one accepted input item
    task automatic predict_plain_text(input html_item_t it);
        text_item_t t;
        step_items.delete();
        if (it.func == FN_BYTE) begin
            p_work[0] = it.text_byte; p_work_len = 1; p_rp = 0;
            drain_work();
        end else begin
            while (p_collect) begin
                entity_replay(); drain_work();
            end
            t.out_byte = CH_NUL; t.repeat_res = 16'd0; t.end_of_text = 1'b1;
            t.last_of_run = 1'b0;
            step_items = {step_items, t};
            reset_predictor();
        end
        if (step_items.size() > 0) step_items[step_items.size() - 1].last_of_run = 1;
        foreach (step_items[i]) expected_text = {expected_text, step_items[i]};
    endtask

    task automatic add_str(input string s);
        html_item_t it;
        for (int i = 0; i < s.len(); i++) begin
            it.func = FN_BYTE; it.text_byte = s[i];
            pending_html = {pending_html, it};
        end
    endtask

    task automatic add_end();
        html_item_t it;
        it.func = FN_END; it.text_byte = 8'($urandom_range(0, 255));
        pending_html = {pending_html, it};
    endtask

    // Random fragment of markup or text
    task automatic add_fragment();
        string frags [24] = '{"<p>", "<br/>", "</div>", "<LI>", "<li>", "<h3 x=1>",
            "<script>a<b>", "</script>", "<style>", "</STYLE>", "&amp;", "&lt;",
            "&nbsp;", "&hellip;", "&#x1F600;", "&#233;", "&#0;", "&bogus;", "&#xZ;",
            "  \t", "\r\n\n\n", "< blockquote >", "<abcdefghijkl>", "&"};
        int k;
        k = $urandom_range(0, 9);
        if (k < 4) add_str(frags[$urandom_range(0, 23)]);
        else if (k < 8) add_str({8'($urandom_range("a", "z")), 8'($urandom_range("A", "Z"))});
        else begin
            html_item_t it;
            it.func = FN_BYTE; it.text_byte = 8'($urandom_range(0, 255));
            pending_html = {pending_html, it};
        end
    endtask

    // Driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            text_in.valid <= 1'b0;
            text_in.func <= FN_BYTE;
            text_in.text_byte <= 8'h00;
        end else if (!text_in.valid || text_in.ready) begin
            if (pending_html.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                html_item_t it;
                it = pending_html.pop_front();
                text_in.valid <= 1'b1;
                text_in.func <= it.func;
                text_in.text_byte <= it.text_byte;
            end else text_in.valid <= 1'b0;
        end
    end

    // Predict on acceptance
    always @(posedge clk) begin
        if (rst_n && text_in.valid && text_in.ready)
            predict_plain_text('{func: text_in.func, text_byte: text_in.text_byte});
    end

    // Monitor and receiver stalls
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) text_out.ready <= 1'b0;
        else begin
            if (text_out.valid && text_out.ready) begin
                text_item_t got, want;
                got = '{text_out.out_byte, text_out.repeat_res, text_out.end_of_text,
                        text_out.last_of_run};
                results_seen++;
                if (got.end_of_text) eot_seen++;
                if (expected_text.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected item: byte %02h rep %0d eot %b last %b",
                                 got.out_byte, got.repeat_res, got.end_of_text,
                                 got.last_of_run);
                end else begin
                    want = expected_text.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp %02h/%0d/%b/%b got %02h/%0d/%b/%b",
                                     want.out_byte, want.repeat_res, want.end_of_text,
                                     want.last_of_run, got.out_byte, got.repeat_res,
                                     got.end_of_text, got.last_of_run);
                    end
                end
            end
            text_out.ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // Watchdog
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) stall_cycles <= 0;
        else begin
            if ((text_in.valid && text_in.ready) || (text_out.valid && text_out.ready))
                stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT && (!stim_done || expected_text.size() > 0)) begin
                $display("timeout with %0d items outstanding", expected_text.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        rst_n = 0; mismatches = 0; results_seen = 0; eot_seen = 0;
        idle_pct = 18; stim_done = 0;
        reset_predictor();
        repeat (6) @(posedge clk);
        rst_n <= 1;

        // Directed: tags, entities, whitespace, end of text
        add_str("<p>A&amp;&#x10FFFF;&#1114112;");
        add_str("<li>x<script>q</script>&toolongentit;");
        add_str(" \t\r\n\n\n\x7f\xff&#99999999;");
        add_end();
        add_str("b  \n&lt");
        add_end();
        add_end();
        while (pending_html.size() > 0) @(posedge clk);

        // No idling for a stretch
        idle_pct = 0;
        repeat (15) add_fragment();
        add_end();
        while (pending_html.size() > 0) @(posedge clk);
        idle_pct = 18;

        // Random texts
        for (int n = 0; n < 6; n++) begin
            repeat ($urandom_range(1, 6)) add_fragment();
            if ($urandom_range(0, 3) == 0) add_end();
        end
        add_end();
        while (pending_html.size() > 0) @(posedge clk);
        stim_done = 1;
        while (expected_text.size() > 0) @(posedge clk);
        repeat (50) @(posedge clk);

        $display("covered %0d result items, %0d ends of text", results_seen, eot_seen);
        if (mismatches == 0 && expected_text.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule
